// ===== hdl/dks_pkg.sv =====
// Shared types, constants and command structs for the dedup key set table.
package dks_pkg;

   localparam int ENTRIES_DEF  = 16;
   localparam int KEY_BITS_DEF = 16;

   localparam int OP_W    = 2;
   localparam int KEY_W   = 16;
   localparam int TOTAL_W = 5;

   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
   localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]  operation;
      logic [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic               was_present;
      logic [TOTAL_W-1:0] element_total;
      logic               add_refused;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic issue;
      logic update;
   } cmd_type;

   typedef struct packed {
      logic last_issue;
      logic out_free;
   } stat_type;

endpackage

// ===== hdl/dedup_key_set_table.sv =====
// A request is accepted only in idle; the scan, drain and update states follow, and update
// waits until the result register is free. The scan reads one key slot per cycle from
// the single read port of the key RAM.
// A finished result waits in an output register while the next request is accepted.
// Reset (synchronous, active high) empties the set: valid bits and count clear at once;
// key RAM contents stay undefined and are never compared until written.
module dedup_key_set_table #(
   parameter int ENTRIES  = dks_pkg::ENTRIES_DEF,
   parameter int KEY_BITS = dks_pkg::KEY_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dks_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dks_pkg::rsp_type rsp_data
);

   dks_pkg::cmd_type  cmd;
   dks_pkg::stat_type stat;

   dks_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .stat     (stat),
      .cmd      (cmd)
   );

   dks_datapath #(
      .ENTRIES (ENTRIES),
      .KEY_BITS(KEY_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

endmodule

// ===== hdl/dks_ram.sv =====
// Generic simple dual-port RAM with registered read.
module dks_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/dks_ctrl.sv =====
// Controller state machine: accept, scan, drain, update.
module dks_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dks_pkg::stat_type stat,
   output dks_pkg::cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_UPDATE
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (stat.last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            // hold until the result register can take the transaction
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready  = (state_ff == ST_IDLE);
   assign cmd.load   = (state_ff == ST_IDLE) && req_valid;
   assign cmd.issue  = (state_ff == ST_SCAN);
   assign cmd.update = (state_ff == ST_UPDATE) && stat.out_free;

endmodule

// ===== hdl/dks_datapath.sv =====
// Datapath: key store, valid bits, scan compare, count and result register.
module dks_datapath #(
   parameter int ENTRIES  = dks_pkg::ENTRIES_DEF,
   parameter int KEY_BITS = dks_pkg::KEY_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  dks_pkg::req_type  req_data,
   input  dks_pkg::cmd_type  cmd,
   output dks_pkg::stat_type stat,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dks_pkg::rsp_type  rsp_data
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   logic [dks_pkg::OP_W-1:0] op_ff;
   logic [KEY_BITS-1:0]      key_ff;
   logic [IDX_W-1:0]         rd_idx_ff, rd_idx_in;
   logic                     cmp_vld_ff;
   logic [IDX_W-1:0]         cmp_idx_ff;
   logic                     hit_ff, hit_in;
   logic [IDX_W-1:0]         hit_idx_ff, hit_idx_in;
   logic                     free_ff, free_in;
   logic [IDX_W-1:0]         free_idx_ff, free_idx_in;
   logic [ENTRIES-1:0]       valid_ff, valid_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   dks_pkg::rsp_type         rsp_ff;
   logic [KEY_BITS-1:0]      rd_key;
   logic                     do_add, do_remove, refused;

   dks_ram #(
      .WIDTH(KEY_BITS),
      .DEPTH(ENTRIES),
      .AW   (IDX_W)
   ) u_key_ram (
      .clock  (clock),
      .wr_en  (cmd.update && do_add),
      .wr_addr(free_idx_ff),
      .wr_data(key_ff),
      .rd_en  (cmd.issue),
      .rd_addr(rd_idx_ff),
      .rd_data(rd_key)
   );

   // scan: issue one read per cycle, compare the returned slot in the cycle after its read
   always_comb begin
      rd_idx_in   = rd_idx_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      if (cmd.load) begin
         rd_idx_in = '0;
         hit_in    = 1'b0;
         free_in   = 1'b0;
      end else begin
         if (cmd.issue && (rd_idx_ff != LAST_IDX)) begin
            rd_idx_in = rd_idx_ff + 1'b1;
         end
         if (cmp_vld_ff) begin
            if (valid_ff[cmp_idx_ff] && (rd_key == key_ff) && !hit_ff) begin
               hit_in     = 1'b1;
               hit_idx_in = cmp_idx_ff;
            end
            if (!valid_ff[cmp_idx_ff] && !free_ff) begin
               free_in     = 1'b1;
               free_idx_in = cmp_idx_ff;
            end
         end
      end
   end

   assign do_add    = (op_ff == dks_pkg::OP_ADD) && !hit_ff && free_ff;
   assign do_remove = (op_ff == dks_pkg::OP_REMOVE) && hit_ff;
   assign refused   = (op_ff == dks_pkg::OP_ADD) && !hit_ff && !free_ff;

   always_comb begin
      valid_in     = valid_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.update) begin
         rsp_valid_in = 1'b1;
         if (do_add) begin
            valid_in[free_idx_ff] = 1'b1;
            count_in              = count_ff + 1'b1;
         end else if (do_remove) begin
            valid_in[hit_idx_ff] = 1'b0;
            count_in             = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         cmp_vld_ff   <= 1'b0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         cmp_vld_ff   <= cmd.issue;
         hit_ff       <= hit_in;
         free_ff      <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      cmp_idx_ff  <= rd_idx_ff;
      hit_idx_ff  <= hit_idx_in;
      free_idx_ff <= free_idx_in;
      if (cmd.load) begin
         op_ff  <= req_data.operation;
         key_ff <= KEY_BITS'(req_data.key);
      end
      if (cmd.update) begin
         rsp_ff.was_present   <= hit_ff;
         rsp_ff.element_total <= dks_pkg::TOTAL_W'(count_in);
         rsp_ff.add_refused   <= refused;
      end
   end

   assign stat.last_issue = (rd_idx_ff == LAST_IDX);
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_ff;

`ifndef SYNTHESIS
   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      count_ff == CNT_W'($countones(valid_ff)))
      else $error("held count disagrees with valid bits");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(ENTRIES))
      else $error("held count above table size");

   a_update_shows_result: assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> rsp_valid_ff)
      else $error("update did not present a result");

   a_refuse_only_absent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.add_refused) |-> !rsp_ff.was_present)
      else $error("refused add reported a present key");
`endif

endmodule
